/* src/olha_pkg.sv */
// Shared types and constants for the light history averager.
`timescale 1ns / 1ps

package olha_pkg;

   localparam int SAMPLE_W          = 12;
   localparam int TENTHS_W          = 10;
   localparam int SUM_W             = 20;
   localparam int COUNT_W           = 8;
   localparam int REQ_DATA_W        = 16;
   localparam int RSP_DATA_W        = 48;
   localparam int FULL_SCALE_TENTHS = 1000;
   localparam int MV_PER_TENTH_DEN  = 33;
   localparam int TENTHS_RECIP      = 127101;
   localparam int TENTHS_RECIP_W    = 17;
   localparam int TENTHS_SHIFT      = 22;
   localparam logic [COUNT_W-1:0] SAMPLES_RESET = 8'd8;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b000_0001,
      ST_DIV_RD   = 7'b000_0010,
      ST_WALK_RD  = 7'b000_0100,
      ST_WALK_CHK = 7'b000_1000,
      ST_DIV_HM   = 7'b001_0000,
      ST_DIV_HT   = 7'b010_0000,
      ST_OUT      = 7'b100_0000
   } state_type;

endpackage

/* src/olha_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module olha_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   assign rem_sh   = {rem_ff, quot_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign fits     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* src/oversampled_light_history_averager_core.sv */
// Top level: oversampling accumulator, reading history and result sequencer.
`timescale 1ns / 1ps

// Sums samples_per_reading samples (0 acts as 1), divides by the count to form a
// reading, stores it in a ring history cleared at reset, and returns one word with
// the reading, the mean of history entries before the first zero, and both as
// clamped tenths of a percent of 3300 mV. A sample that does not close a group
// only adds to the group sum. A closing sample runs up to three divisions on one
// shared bit-serial divider of W bits (W = max(20, 16 + clog2(HISTORY_DEPTH + 1)),
// 21 by default) and walks the history entries through the registered memory
// port. The reading's tenths come from a constant reciprocal multiply. req_tready
// is low until the result is loaded into the output register; a finished result
// waits there without blocking the next sample.
module oversampled_light_history_averager_core #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [olha_pkg::COUNT_W-1:0]        csr_wdata,     // samples_per_reading
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [olha_pkg::REQ_DATA_W-1:0]     req_tdata,     // [11:0] sample_mv
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] reading_mv, [21:12] reading_percent_tenths,
   // [33:22] history_mean_mv, [43:34] history_percent_tenths
   output logic [olha_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int SW   = olha_pkg::SAMPLE_W;
   localparam int TW   = olha_pkg::TENTHS_W;
   localparam int SUMW = olha_pkg::SUM_W;
   localparam int CW   = olha_pkg::COUNT_W;
   localparam int PW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
   localparam int HSW  = SW + HCW;
   localparam int NW   = (HSW + 4 > SUMW) ? HSW + 4 : SUMW;
   localparam int DW   = (HCW + 6 > CW + 1) ? HCW + 6 : CW + 1;
   localparam int RXW  = SW + 4;
   localparam int RPW  = RXW + olha_pkg::TENTHS_RECIP_W;

   olha_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   spr_ff, spr_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [CW-1:0]   taken_ff, taken_in;
   logic [PW-1:0]   wp_ff, wp_in;
   logic [HCW-1:0]  idx_ff, idx_in;
   logic [HCW-1:0]  n_ff, n_in;
   logic [HSW-1:0]  hsum_ff, hsum_in;
   logic [SW-1:0]   reading_ff, reading_in;
   logic [TW-1:0]   rt_ff, rt_in;
   logic [SW-1:0]   mean_ff, mean_in;
   logic [TW-1:0]   ht_ff, ht_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [olha_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SW-1:0]            hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff;
   logic [SW-1:0]            rd_data_ff;
   logic                     rd_valid_ff;
   logic                     hist_we;
   logic                     rd_en;
   logic [PW-1:0]            rd_addr;

   logic [CW-1:0]   target;
   logic [SUMW-1:0] sum_acc;
   logic [CW:0]     count_acc;
   logic            group_done;

   logic            div_start;
   logic [NW-1:0]   div_num;
   logic [DW-1:0]   div_den;
   logic            div_done;
   logic [NW-1:0]   div_quot;
   logic [TW-1:0]   quot_tenths;
   logic [NW-1:0]   hsum_x10;
   logic [DW-1:0]   n_x33;
   logic [RXW-1:0]  rt_x10;
   logic [RPW-1:0]  rt_prod;
   logic [TW:0]     rt_quot;
   logic [TW-1:0]   rt_tenths;

   olha_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_tready = (state_ff == olha_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign target     = (spr_ff == '0) ? CW'(1) : spr_ff;
   assign sum_acc    = sum_ff + SUMW'(req_tdata[SW-1:0]);
   assign count_acc  = {1'b0, taken_ff} + (CW + 1)'(1);
   assign group_done = count_acc >= {1'b0, target};

   assign hsum_x10    = (NW'(hsum_ff) << 3) + (NW'(hsum_ff) << 1);
   assign n_x33       = (DW'(n_ff) << 5) + DW'(n_ff);
   assign quot_tenths = (div_quot > NW'(olha_pkg::FULL_SCALE_TENTHS))
                        ? TW'(olha_pkg::FULL_SCALE_TENTHS) : div_quot[TW-1:0];

   assign rt_x10    = (RXW'(div_quot[SW-1:0]) << 3) + (RXW'(div_quot[SW-1:0]) << 1);
   assign rt_prod   = RPW'(rt_x10) * RPW'(olha_pkg::TENTHS_RECIP);
   assign rt_quot   = rt_prod[olha_pkg::TENTHS_SHIFT +: TW + 1];
   assign rt_tenths = (rt_quot > (TW + 1)'(olha_pkg::FULL_SCALE_TENTHS))
                      ? TW'(olha_pkg::FULL_SCALE_TENTHS) : rt_quot[TW-1:0];

   assign rd_addr = idx_ff[PW-1:0];

   always_comb begin
      state_in      = state_ff;
      spr_in        = csr_we ? csr_wdata : spr_ff;
      sum_in        = sum_ff;
      taken_in      = taken_ff;
      wp_in         = wp_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      hsum_in       = hsum_ff;
      reading_in    = reading_ff;
      rt_in         = rt_ff;
      mean_in       = mean_ff;
      ht_in         = ht_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      hist_we       = 1'b0;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      case (state_ff)
         olha_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (group_done) begin
                  div_start = 1'b1;
                  div_num   = NW'(sum_acc);
                  div_den   = DW'(count_acc);
                  sum_in    = '0;
                  taken_in  = '0;
                  state_in  = olha_pkg::ST_DIV_RD;
               end else begin
                  sum_in   = sum_acc;
                  taken_in = count_acc[CW-1:0];
               end
            end
         end
         olha_pkg::ST_DIV_RD: begin
            if (div_done) begin
               reading_in = div_quot[SW-1:0];
               rt_in      = rt_tenths;
               hist_we    = 1'b1;
               wp_in      = (wp_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
               idx_in     = '0;
               n_in       = '0;
               hsum_in    = '0;
               state_in   = olha_pkg::ST_WALK_RD;
            end
         end
         olha_pkg::ST_WALK_RD: begin
            if (idx_ff == HCW'(HISTORY_DEPTH)) begin
               div_start = 1'b1;
               div_num   = NW'(hsum_ff);
               div_den   = DW'(n_ff);
               state_in  = olha_pkg::ST_DIV_HM;
            end else begin
               rd_en    = 1'b1;
               state_in = olha_pkg::ST_WALK_CHK;
            end
         end
         olha_pkg::ST_WALK_CHK: begin
            if (rd_valid_ff && (rd_data_ff != '0)) begin
               hsum_in  = hsum_ff + HSW'(rd_data_ff);
               n_in     = n_ff + HCW'(1);
               idx_in   = idx_ff + HCW'(1);
               state_in = olha_pkg::ST_WALK_RD;
            end else if (n_ff == '0) begin
               mean_in  = '0;
               ht_in    = '0;
               state_in = olha_pkg::ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = NW'(hsum_ff);
               div_den   = DW'(n_ff);
               state_in  = olha_pkg::ST_DIV_HM;
            end
         end
         olha_pkg::ST_DIV_HM: begin
            if (div_done) begin
               mean_in   = div_quot[SW-1:0];
               div_start = 1'b1;
               div_num   = hsum_x10;
               div_den   = n_x33;
               state_in  = olha_pkg::ST_DIV_HT;
            end
         end
         olha_pkg::ST_DIV_HT: begin
            if (div_done) begin
               ht_in    = quot_tenths;
               state_in = olha_pkg::ST_OUT;
            end
         end
         olha_pkg::ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {4'b0000, ht_ff, mean_ff, rt_ff, reading_ff};
               state_in      = olha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= div_quot[SW-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (hist_we) begin
            hist_valid_ff[wp_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= hist_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= olha_pkg::ST_IDLE;
         spr_ff        <= olha_pkg::SAMPLES_RESET;
         sum_ff        <= '0;
         taken_ff      <= '0;
         wp_ff         <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spr_ff        <= spr_in;
         sum_ff        <= sum_in;
         taken_ff      <= taken_in;
         wp_ff         <= wp_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      hsum_ff     <= hsum_in;
      reading_ff  <= reading_in;
      rt_ff       <= rt_in;
      mean_ff     <= mean_in;
      ht_ff       <= ht_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* bench/tb.sv */
// Self-checking bench for the oversampled light history averager core.
`timescale 1ns / 1ps

module tb;

   localparam int SAMPLE_W          = olha_pkg::SAMPLE_W;
   localparam int TENTHS_W          = olha_pkg::TENTHS_W;
   localparam int SUM_W             = olha_pkg::SUM_W;
   localparam int COUNT_W           = olha_pkg::COUNT_W;
   localparam int REQ_DATA_W        = olha_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W        = olha_pkg::RSP_DATA_W;
   localparam int FULL_SCALE_TENTHS = olha_pkg::FULL_SCALE_TENTHS;
   localparam int MV_PER_TENTH_DEN  = olha_pkg::MV_PER_TENTH_DEN;
   localparam logic [COUNT_W-1:0] SAMPLES_RESET = olha_pkg::SAMPLES_RESET;

   localparam int HIST_DEPTH  = 16;
   localparam int SETTLE      = 160;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] reading_mv;
      logic [TENTHS_W-1:0] reading_tenths;
      logic [SAMPLE_W-1:0] history_mean_mv;
      logic [TENTHS_W-1:0] history_tenths;
   } light_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_HALF
   } rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [COUNT_W-1:0]    csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [11:0] sample_mv
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [11:0] reading_mv, [21:12] reading_percent_tenths,
   // [33:22] history_mean_mv, [43:34] history_percent_tenths
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictor state
   logic [COUNT_W-1:0]    group_target = SAMPLES_RESET;
   logic [SUM_W-1:0]      group_sum = '0;
   logic [COUNT_W-1:0]    group_count = '0;
   logic [SAMPLE_W-1:0]   history_mem [HIST_DEPTH];
   int unsigned           write_slot = 0;

   light_result_type      readings_due [$];
   int unsigned           error_count = 0;
   int unsigned           samples_sent = 0;
   int unsigned           readings_checked = 0;
   int unsigned           settings_used = 0;
   int unsigned           burst_left = 1;
   int unsigned           cycle_count = 0;
   rx_mode_type           rx_mode = RX_OPEN;

   oversampled_light_history_averager_core #(
      .HISTORY_DEPTH (HIST_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("oversampled_light_history_averager_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count[7:0] == 8'd0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (cycle_count[3:0] == 4'd0);
         default:   rsp_tready <= cycle_count[2];
      endcase
   end

   function automatic logic [TENTHS_W-1:0] mv_to_tenths(input longint unsigned num,
                                                         input longint unsigned den);
      longint unsigned t;
      if (den == 0) return '0;
      t = (num * 10) / (den * MV_PER_TENTH_DEN);
      if (t > FULL_SCALE_TENTHS) t = FULL_SCALE_TENTHS;
      return t[TENTHS_W-1:0];
   endfunction

   task automatic absorb_sample(input logic [SAMPLE_W-1:0] sample);
      int unsigned      target;
      int unsigned      count;
      int unsigned      reading;
      int unsigned      walked;
      int unsigned      walk_sum;
      light_result_type r;
      target = (group_target == 0) ? 1 : group_target;
      group_sum = group_sum + SUM_W'(sample);
      count = group_count + 1;
      if (count < target) begin
         group_count = COUNT_W'(count);
         return;
      end
      reading = (group_sum / count) & 12'hFFF;
      group_sum = '0;
      group_count = '0;
      history_mem[write_slot] = SAMPLE_W'(reading);
      write_slot = (write_slot + 1) % HIST_DEPTH;
      walked = 0;
      walk_sum = 0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         if (history_mem[i] == 0) break;
         walk_sum += history_mem[i];
         walked++;
      end
      r.reading_mv      = SAMPLE_W'(reading);
      r.reading_tenths  = mv_to_tenths(reading, 1);
      r.history_mean_mv = (walked == 0) ? '0 : SAMPLE_W'(walk_sum / walked);
      r.history_tenths  = mv_to_tenths(walk_sum, walked);
      readings_due.push_back(r);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      light_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (readings_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = readings_due.pop_front();
            check_field("reading_mv", want.reading_mv, rsp_tdata[11:0]);
            check_field("reading_percent_tenths", want.reading_tenths, rsp_tdata[21:12]);
            check_field("history_mean_mv", want.history_mean_mv, rsp_tdata[33:22]);
            check_field("history_percent_tenths", want.history_tenths, rsp_tdata[43:34]);
            readings_checked++;
         end
      end
   end

   // Leaves req_tvalid high; the caller drops it when a gap follows.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - SAMPLE_W){1'b0}}, sample};
      do @(posedge clock); while (!req_tready);
      absorb_sample(sample);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_samples_per_reading(input logic [COUNT_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      group_target = value;
      settings_used++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 12'hFFF;
         2:       return SAMPLE_W'($urandom_range(3290, 3310));
         3:       return SAMPLE_W'($urandom_range(1, 40));
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic pace_sender();
      int unsigned gap;
      burst_left--;
      if (burst_left != 0) return;
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if ($urandom_range(0, 99) == 0) begin
         wait_drained();
      end else if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_default_group();
      repeat (8) send_sample(12'hFFF);
   endtask

   task automatic test_single_sample_edges();
      logic [SAMPLE_W-1:0] edges [6] = '{12'd0, 12'd3300, 12'd3299, 12'd1, 12'd33, 12'd3301};
      write_samples_per_reading(8'd1);
      foreach (edges[i]) send_sample(edges[i]);
   endtask

   task automatic test_zero_setting();
      write_samples_per_reading(8'd0);
      send_sample(12'hFFF);
      send_sample(12'd2);
   endtask

   task automatic test_lowered_mid_group();
      write_samples_per_reading(8'd3);
      send_sample(12'd100);
      send_sample(12'd4000);
      write_samples_per_reading(8'd2);
      send_sample(12'd7);
      send_sample(12'd5);
      send_sample(12'd6);
   endtask

   task automatic test_random_phases();
      logic [COUNT_W-1:0] phase_setting [7];
      int unsigned        phase_items [7] = '{300, 100, 120, 90, 255, 120, 115};
      phase_setting = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd255,
                        COUNT_W'($urandom_range(4, 16)), 8'd1};
      foreach (phase_setting[p]) begin
         write_samples_per_reading(phase_setting[p]);
         repeat (phase_items[p]) begin
            send_sample(pick_sample());
            pace_sender();
         end
      end
   endtask

   initial begin
      foreach (history_mem[i]) history_mem[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      test_default_group();
      test_single_sample_edges();
      test_zero_setting();
      test_lowered_mid_group();
      test_random_phases();

      wait_drained();
      $display("Covered %0d samples and %0d readings over %0d register settings,",
               samples_sent, readings_checked, settings_used);
      $display("including zero and full-scale groups, history wrap and mid-group changes.");
      if (error_count == 0) begin
         $display("oversampled_light_history_averager_core verification clean");
      end else begin
         $display("oversampled_light_history_averager_core verification failed");
      end
      $finish;
   end

endmodule
